@@ design/lbrh_pkg.sv @@
// Package for the log-binned radius histogram: sizes, state and command types.
// Used by every module in the design folder; depends on nothing.
package lbrh_pkg;

    localparam int BINS = 1600;
    localparam int BIN_W = 11;
    localparam int CNT_W = 32;
    localparam int FRAC_BITS = 24;
    localparam logic [28:0] LN2_Q28 = 29'd186065279;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [0:0] REQ_SAMPLE = 1'b0;
    localparam logic [0:0] REQ_READ = 1'b1;

    localparam logic [0:0] REG_LOG_MIN = 1'b0;
    localparam logic [0:0] REG_LOG_MAX = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NORM,
        ST_SQR,
        ST_MUL,
        ST_RANGE,
        ST_DIV,
        ST_RD,
        ST_WR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic norm_step;
        logic sqr_start;
        logic sqr_step;
        logic mul_lo;
        logic mul_hi;
        logic range_chk;
        logic div_start;
        logic div_step;
        logic mem_rd;
        logic mem_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_read;
        logic skip;
        logic norm_done;
        logic sqr_done;
        logic in_range;
        logic div_done;
    } t_status;

endpackage

@@ design/lbrh_ctrl.sv @@
// Controller state machine for the log-binned radius histogram.
// Depends on lbrh_pkg; drives lbrh_datapath through command signals only.
module lbrh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_busy,
    input  lbrh_pkg::t_status i_status,
    output lbrh_pkg::t_cmd    o_cmd
);

    lbrh_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbrh_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lbrh_pkg::ST_CLEAR: if (i_status.clr_done) n_state = lbrh_pkg::ST_IDLE;
            lbrh_pkg::ST_IDLE:  if (i_in_valid) n_state = lbrh_pkg::ST_NORM;
            lbrh_pkg::ST_NORM: begin
                if (i_status.is_read) n_state = lbrh_pkg::ST_RD;
                else if (i_status.skip) n_state = lbrh_pkg::ST_OUT;
                else if (i_status.norm_done) n_state = lbrh_pkg::ST_SQR;
            end
            lbrh_pkg::ST_SQR:   if (i_status.sqr_done) n_state = lbrh_pkg::ST_MUL;
            lbrh_pkg::ST_MUL:   n_state = lbrh_pkg::ST_RANGE;
            lbrh_pkg::ST_RANGE: n_state = i_status.in_range ? lbrh_pkg::ST_DIV
                                                            : lbrh_pkg::ST_OUT;
            lbrh_pkg::ST_DIV:   if (i_status.div_done) n_state = lbrh_pkg::ST_RD;
            lbrh_pkg::ST_RD:    n_state = i_status.is_read ? lbrh_pkg::ST_OUT
                                                           : lbrh_pkg::ST_WR;
            lbrh_pkg::ST_WR:    n_state = lbrh_pkg::ST_OUT;
            lbrh_pkg::ST_OUT:   if (!i_out_busy) n_state = lbrh_pkg::ST_IDLE;
            default:            n_state = lbrh_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lbrh_pkg::ST_CLEAR: o_cmd.clr_step = 1'b1;
            lbrh_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            lbrh_pkg::ST_NORM: begin
                o_cmd.norm_step = 1'b1;
                o_cmd.sqr_start = i_status.norm_done;
                o_cmd.mem_rd = i_status.is_read;
            end
            lbrh_pkg::ST_SQR: begin
                o_cmd.sqr_step = 1'b1;
                o_cmd.mul_lo = i_status.sqr_done;
            end
            lbrh_pkg::ST_MUL: o_cmd.mul_hi = 1'b1;
            lbrh_pkg::ST_RANGE: begin
                o_cmd.range_chk = 1'b1;
                o_cmd.div_start = 1'b1;
            end
            lbrh_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            lbrh_pkg::ST_RD: begin
                o_cmd.out_load = i_status.is_read;
                o_cmd.mem_rd = !i_status.is_read;
            end
            lbrh_pkg::ST_WR: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.out_load = 1'b1;
            end
            lbrh_pkg::ST_OUT: o_cmd.out_load = 1'b0;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ design/lbrh_datapath.sv @@
// Datapath of the log-binned radius histogram: log unit, binning divider,
// bin memory and result register. Depends on lbrh_pkg; commanded by lbrh_ctrl.
module lbrh_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lbrh_pkg::t_cmd             i_cmd,
    output lbrh_pkg::t_status          o_status,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [31:0]                i_cfg_data,
    input  logic                       i_req_type,
    input  logic [63:0]                i_radius_bits,
    input  logic                       i_last_of_set,
    input  logic [lbrh_pkg::BIN_W-1:0] i_read_bin,
    output logic                       o_counted,
    output logic [lbrh_pkg::BIN_W-1:0] o_bin_number,
    output logic [lbrh_pkg::CNT_W-1:0] o_bin_count,
    output logic [lbrh_pkg::CNT_W-1:0] o_measurement_count
);

    logic signed [31:0] r_log_min, r_log_max;
    logic r_is_read, r_skip, r_counted, r_sub;
    logic [51:0] r_frac;
    logic [5:0] r_pos;
    logic signed [11:0] r_exp;
    logic [32:0] r_m;
    logic [23:0] r_fr;
    logic [4:0] r_sqr_cnt;
    logic signed [36:0] r_lg;
    logic signed [66:0] r_prod_lo;
    logic [43:0] r_num;
    logic [32:0] r_den;
    logic [32:0] r_rem;
    logic [lbrh_pkg::BIN_W-1:0] r_quo;
    logic [5:0] r_div_cnt;
    logic [lbrh_pkg::BIN_W-1:0] r_bin;
    logic [lbrh_pkg::BIN_W-1:0] r_clr_addr;
    logic [lbrh_pkg::CNT_W-1:0] r_rd_data, r_sets;
    logic r_rd_ok;
    logic [lbrh_pkg::CNT_W-1:0] r_mem [lbrh_pkg::BINS];

    logic [63:0] w_sq;
    logic [33:0] w_trial;
    logic signed [31:0] w_l;
    logic signed [32:0] w_diff;
    logic [lbrh_pkg::CNT_W-1:0] w_inc;

    assign o_status.clr_done  = (r_clr_addr == lbrh_pkg::BIN_W'(lbrh_pkg::BINS - 1));
    assign o_status.is_read   = r_is_read;
    assign o_status.skip      = r_skip;
    assign o_status.norm_done = r_frac[51] || (r_pos == 6'd0);
    assign o_status.sqr_done  = (r_sqr_cnt == 5'(lbrh_pkg::FRAC_BITS - 1));
    assign o_status.in_range  = (w_l >= r_log_min) && (w_l < r_log_max);
    assign o_status.div_done  = (r_div_cnt == 6'd0);

    // Natural log in Q.20, floored by the arithmetic shift.
    assign w_l = 32'(r_prod_lo >>> 32);
    assign w_sq = 64'(r_m[31:0]) * 64'(r_m[31:0]);
    assign w_diff = 33'(w_l) - 33'(r_log_min);
    assign w_trial = {r_rem, r_num[43]} - {1'b0, r_den};
    assign w_inc = (r_rd_data == lbrh_pkg::CNT_MAX) ? r_rd_data : r_rd_data + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_min <= -32'sd41943040;
            r_log_max <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == lbrh_pkg::REG_LOG_MIN) r_log_min <= i_cfg_data;
            else r_log_max <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_sets <= '0;
        end else begin
            if (i_cmd.clr_step && !o_status.clr_done) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.load && i_req_type == lbrh_pkg::REQ_SAMPLE && i_last_of_set &&
                r_sets != lbrh_pkg::CNT_MAX) r_sets <= r_sets + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_read <= (i_req_type == lbrh_pkg::REQ_READ);
            r_skip <= i_radius_bits[63] || (i_radius_bits[62:0] == '0) ||
                      (i_radius_bits[62:52] == 11'h7FF);
            r_frac <= i_radius_bits[51:0];
            r_counted <= 1'b0;
            r_bin <= i_read_bin;
            r_sub <= (i_radius_bits[62:52] == '0);
            if (i_radius_bits[62:52] == '0) begin
                r_exp <= -12'sd1023;
                r_pos <= 6'd51;
            end else begin
                r_exp <= 12'(i_radius_bits[62:52]) - 12'sd1023;
                r_pos <= 6'd0;
            end
        end
        if (i_cmd.norm_step && !o_status.norm_done) begin
            r_frac <= {r_frac[50:0], 1'b0};
            r_pos <= r_pos - 1'b1;
            r_exp <= r_exp - 1'b1;
        end
        if (i_cmd.sqr_start) begin
            // Subnormal: the leading one now sits at the top and is dropped.
            r_m <= {2'b01, r_sub ? r_frac[50:20] : r_frac[51:21]};
            r_fr <= '0;
            r_sqr_cnt <= '0;
        end
        if (i_cmd.sqr_step) begin
            r_sqr_cnt <= r_sqr_cnt + 1'b1;
            if (w_sq[63]) begin
                r_m <= {1'b0, w_sq[63:32]};
                r_fr <= {r_fr[22:0], 1'b1};
            end else begin
                r_m <= {1'b0, w_sq[62:31]};
                r_fr <= {r_fr[22:0], 1'b0};
            end
        end
        if (i_cmd.mul_lo) begin
            r_lg <= 37'($signed({r_exp, r_fr[22:0], w_sq[63]}));
        end
        if (i_cmd.mul_hi) begin
            r_prod_lo <= 67'(r_lg) * $signed({38'd0, lbrh_pkg::LN2_Q28});
        end
        if (i_cmd.div_start) begin
            r_num <= 44'(w_diff) * 44'(lbrh_pkg::BINS);
            r_den <= 33'(33'(r_log_max) - 33'(r_log_min));
            r_rem <= '0;
            r_quo <= '0;
            r_div_cnt <= 6'd44;
        end
        if (i_cmd.div_step && !o_status.div_done) begin
            r_num <= {r_num[42:0], 1'b0};
            r_div_cnt <= r_div_cnt - 1'b1;
            if (!w_trial[33]) begin
                r_rem <= w_trial[32:0];
                r_quo <= {r_quo[lbrh_pkg::BIN_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_num[43]};
                r_quo <= {r_quo[lbrh_pkg::BIN_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_step && o_status.div_done) begin
            r_bin <= (r_quo >= lbrh_pkg::BIN_W'(lbrh_pkg::BINS)) ?
                     lbrh_pkg::BIN_W'(lbrh_pkg::BINS - 1) : r_quo;
            r_counted <= 1'b1;
        end
    end

    // Bin store; its entries are cleared in address order after reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) r_mem[r_clr_addr] <= '0;
        else if (i_cmd.mem_wr) r_mem[r_bin] <= w_inc;
        if (i_cmd.mem_rd) begin
            r_rd_ok <= (r_bin < lbrh_pkg::BIN_W'(lbrh_pkg::BINS));
            r_rd_data <= r_mem[(r_bin < lbrh_pkg::BIN_W'(lbrh_pkg::BINS)) ? r_bin : '0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_counted <= 1'b0;
            o_bin_number <= '0;
            o_bin_count <= '0;
        end
        if (i_cmd.out_load) begin
            o_counted <= r_counted;
            o_bin_number <= r_bin;
            o_bin_count <= r_is_read ? (r_rd_ok ? r_rd_data : '0) : w_inc;
        end
        o_measurement_count <= r_sets;
    end

endmodule

@@ design/log_binned_radius_histogram.sv @@
// Top level of the log-binned radius histogram.
// Depends on lbrh_pkg, lbrh_ctrl and lbrh_datapath.
//
// Each input item is a sample (a positive double radius) or a bin read. A
// sample's natural log is formed in signed Q11.20 and, when it lies in
// [log_min, log_max), the matching bin count is bumped with saturation. Every
// item gives one result. Items are handled one at a time: a read goes
// straight to the memory read, an ignored radius straight to the result, a
// normal sample through the 24 squaring steps of the log unit and, when
// inside the range, on through the restoring binning divider and the memory
// update; subnormals are first normalized by shifting. A stalled sink holds
// the block in its output state until the result is taken. After reset a
// clearing pass zeroes all 1600 bins of the bin memory while no item is
// accepted; configuration writes are taken at any time and must occur only
// while the block is idle.
module log_binned_radius_histogram (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: radius_bits[63:0], read_bin[74:64], zero pad [79:75]
    input  logic [79:0] s_axis_tdata,
    // tuser: req_type
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: counted[0], bin_number[11:1], bin_count[43:12],
    // measurement_count[75:44], zero pad [79:76]
    output logic [79:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    lbrh_pkg::t_cmd    w_cmd;
    lbrh_pkg::t_status w_status;
    logic r_out_valid;
    logic w_counted;
    logic [lbrh_pkg::BIN_W-1:0] w_bin;
    logic [lbrh_pkg::CNT_W-1:0] w_cnt, w_meas;

    assign o_cfg_ready = 1'b1;

    lbrh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_out_busy(r_out_valid && !m_axis_tready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    lbrh_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_status(w_status),
        .i_cfg_we(i_cfg_valid), .i_cfg_idx(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req_type(s_axis_tuser), .i_radius_bits(s_axis_tdata[63:0]),
        .i_last_of_set(s_axis_tlast), .i_read_bin(s_axis_tdata[74:64]),
        .o_counted(w_counted), .o_bin_number(w_bin),
        .o_bin_count(w_cnt), .o_measurement_count(w_meas)
    );

    // The result is shown from the output state until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_out_valid && m_axis_tready) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_status.skip && w_cmd.norm_step && !w_status.is_read) begin
            r_out_valid <= 1'b1;
        end else if (w_cmd.range_chk && !w_status.in_range) begin
            r_out_valid <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {4'd0, w_meas, w_cnt, w_bin, w_counted};

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !s_axis_tready)
        else $error("input accepted while a result waits");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> r_out_valid)
        else $error("result dropped before taken");
    a_read_uncounted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && w_status.is_read) |-> !w_counted)
        else $error("read marked as counted");

endmodule

@@ test/tb.sv @@
// Testbench for the log-binned radius histogram: directed table, then random items.
// Depends on lbrh_pkg and log_binned_radius_histogram; results are checked by an
// internal predictor of the log, binning, saturation and set counting.
`timescale 1ns / 100ps

module tb;

    localparam logic [63:0] D_ONE     = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] D_HALF    = 64'h3FE0_0000_0000_0000;
    localparam logic [63:0] D_INF     = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] D_NAN     = 64'h7FF8_0000_0000_0001;
    localparam logic [63:0] D_NEG0    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] D_NEG     = 64'hBFF0_0000_0000_0000;
    localparam logic [63:0] D_SUB_MIN = 64'h0000_0000_0000_0001;
    localparam logic [63:0] D_SUB_MAX = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] D_MAXFIN  = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] D_EM20    = 64'h3E7A_D7F2_9ABC_AF48; // about 1e-7
    localparam int MAX_CYCLES = 2_000_000;
    localparam int NUM_ROWS = 18;

    typedef struct packed {
        logic        rd;
        logic [63:0] radius;
        logic        last;
        logic [10:0] bin;
    } t_item;

    // Field order puts counted in the lowest bit, as on the result bus.
    typedef struct packed {
        logic [31:0] sets;
        logic [31:0] count;
        logic [10:0] bin;
        logic        counted;
    } t_result;

    typedef struct {
        t_item item;
        logic  has_exp;  // expectation typed into the table, checked against the result
        logic  counted;
        logic [10:0] bin;
        logic [31:0] count;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [0:0] i_cfg_index = lbrh_pkg::REG_LOG_MIN;
    logic [31:0] i_cfg_data = '0;

    // Predictor state: a private copy of the histogram and the range registers.
    logic [31:0] hist [lbrh_pkg::BINS];
    logic [31:0] sets_seen;
    logic signed [31:0] lo_bound, hi_bound;
    t_result pending_results [$];
    int errors = 0;
    int cycles = 0;
    logic hold_long = 1'b0;

    log_binned_radius_histogram dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Natural log in Q.20, floored, following the squaring recurrence.
    function automatic longint ln_fixed(logic [63:0] bits);
        logic [51:0] f;
        longint e;
        logic [63:0] m;
        logic [23:0] fr;
        longint lg;
        logic signed [127:0] prod;
        int p;
        f = bits[51:0];
        fr = '0;
        if (bits[62:52] == 0) begin
            p = 51;
            while (p > 0 && f[p] == 1'b0) p--;
            e = p - 1074;
            f = f << (52 - p);
        end else begin
            e = longint'(bits[62:52]) - 1023;
        end
        m = {32'd0, 1'b1, f[51:21]};
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'h1_0000_0000) begin
                fr[0] = 1'b1;
                m = m >> 1;
            end
        end
        lg = e * (longint'(1) << 24) + longint'(fr);
        prod = 128'(lg) * 128'sd186065279;
        return longint'(prod >>> 32);  // arithmetic shift floors toward minus infinity
    endfunction

    function automatic t_result predict_histogram(t_item it);
        t_result r;
        longint lval, num, den, b;
        r = '0;
        if (it.rd) begin
            r.bin = it.bin;
            if (it.bin < lbrh_pkg::BINS) r.count = hist[it.bin];
        end else begin
            if (!it.radius[63] && it.radius[62:0] != 0 && it.radius[62:52] != 11'h7FF) begin
                lval = ln_fixed(it.radius);
                if (lval >= longint'(lo_bound) && lval < longint'(hi_bound)) begin
                    num = (lval - longint'(lo_bound)) * lbrh_pkg::BINS;
                    den = longint'(hi_bound) - longint'(lo_bound);
                    b = num / den;
                    if (b >= lbrh_pkg::BINS) b = lbrh_pkg::BINS - 1;
                    if (hist[b] != lbrh_pkg::CNT_MAX) hist[b] = hist[b] + 1;
                    r.counted = 1'b1;
                    r.bin = b[10:0];
                    r.count = hist[b];
                end
            end
            if (it.last && sets_seen != lbrh_pkg::CNT_MAX) sets_seen = sets_seen + 1;
        end
        r.sets = sets_seen;
        return r;
    endfunction

    task automatic write_register(logic [0:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == lbrh_pkg::REG_LOG_MIN) lo_bound = val; else hi_bound = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sends one item after a random gap; the expectation is queued when it is accepted.
    // Returns at the accepting edge so that a following item can be offered at once.
    task automatic send_item(t_item it, int gap);
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.rd;
        s_axis_tlast <= it.last;
        s_axis_tdata <= {5'd0, it.bin, it.radius};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results = {pending_results, predict_histogram(it)};
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);  // a subnormal sample is the slowest item
    endtask

    function automatic t_item random_item(logic allow_reads);
        t_item it;
        logic [10:0] ex;
        it.rd = allow_reads && ($urandom_range(0, 5) == 0);
        it.last = ($urandom_range(0, 7) == 0);
        it.bin = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(1600, 2047))
                                             : 11'($urandom_range(0, 1599));
        case ($urandom_range(0, 9))
            0: it.radius = {$urandom, $urandom};
            1: it.radius = {12'($urandom_range(0, 1) ? 12'h000 : 12'h7FF),
                            20'($urandom), $urandom};
            default: begin
                ex = 11'($urandom_range(1023 - 60, 1023 + 2));
                it.radius = {1'b0, ex, 20'($urandom), $urandom};
            end
        endcase
        return it;
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[75:0];
            if (pending_results.size() == 0) begin
                $error("result with no expectation: %h", got);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.counted !== exp_r.counted) begin
                    $error("counted exp %0d got %0d", exp_r.counted, got.counted); errors++;
                end
                if (got.bin !== exp_r.bin) begin
                    $error("bin_number exp %0d got %0d", exp_r.bin, got.bin); errors++;
                end
                if (got.count !== exp_r.count) begin
                    $error("bin_count exp %0d got %0d", exp_r.count, got.count); errors++;
                end
                if (got.sets !== exp_r.sets) begin
                    $error("measurement_count exp %0d got %0d", exp_r.sets, got.sets);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls per item, plus one long hold-off when asked.
    initial begin
        int wait_n;
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                hold_long = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (wait_n != 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_row rows [NUM_ROWS];
        t_row row;
        int bursty;
        int last_idx;
        for (int i = 0; i < lbrh_pkg::BINS; i++) hist[i] = '0;
        sets_seen = '0;
        lo_bound = -32'sd41943040;
        hi_bound = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: {read, radius, last, bin}, then the typed expectation.
        rows[0]  = '{'{1'b1, 64'd0, 1'b0, 11'd0},       1, 0, 11'd0, 32'd0};
        rows[1]  = '{'{1'b1, 64'd0, 1'b1, 11'd1599},    1, 0, 11'd1599, 32'd0};
        rows[2]  = '{'{1'b1, 64'd0, 1'b0, 11'd2047},    1, 0, 11'd2047, 32'd0};
        rows[3]  = '{'{1'b0, 64'd0, 1'b1, 11'd0},       1, 0, 11'd0, 32'd0};
        rows[4]  = '{'{1'b0, D_NEG0, 1'b0, 11'd5},      1, 0, 11'd0, 32'd0};
        rows[5]  = '{'{1'b0, D_NEG, 1'b1, 11'd0},       1, 0, 11'd0, 32'd0};
        rows[6]  = '{'{1'b0, D_INF, 1'b0, 11'd0},       1, 0, 11'd0, 32'd0};
        rows[7]  = '{'{1'b0, D_NAN, 1'b0, 11'd0},       1, 0, 11'd0, 32'd0};
        rows[8]  = '{'{1'b0, D_ONE, 1'b0, 11'd0},       1, 0, 11'd0, 32'd0};
        rows[9]  = '{'{1'b0, D_MAXFIN, 1'b0, 11'd0},    1, 0, 11'd0, 32'd0};
        rows[10] = '{'{1'b0, D_SUB_MIN, 1'b0, 11'd0},   1, 0, 11'd0, 32'd0};
        rows[11] = '{'{1'b0, D_SUB_MAX, 1'b1, 11'd0},   1, 0, 11'd0, 32'd0};
        rows[12] = '{'{1'b0, D_HALF, 1'b0, 11'd0},      0, 0, 11'd0, 32'd0};
        rows[13] = '{'{1'b0, D_HALF, 1'b0, 11'd0},      0, 0, 11'd0, 32'd0};
        rows[14] = '{'{1'b0, D_EM20, 1'b1, 11'd0},      0, 0, 11'd0, 32'd0};
        rows[15] = '{'{1'b0, 64'h3FEF_FFFF_FFFF_FFFF, 1'b0, 11'd0}, 0, 0, 11'd0, 32'd0};
        rows[16] = '{'{1'b0, 64'h3E60_0000_0000_0000, 1'b0, 11'd0}, 0, 0, 11'd0, 32'd0};
        rows[17] = '{'{1'b1, {64{1'b1}}, 1'b1, 11'd1024}, 0, 0, 11'd0, 32'd0};
        foreach (rows[i]) begin
            row = rows[i];
            send_item(row.item, $urandom_range(0, 14));
            if (row.has_exp) begin
                // The typed fields stand in for the predicted ones of this row.
                last_idx = pending_results.size() - 1;
                pending_results[last_idx].counted = row.counted;
                pending_results[last_idx].bin = row.bin;
                pending_results[last_idx].count = row.count;
            end
        end
        drain_results();

        // Phases over several ranges, extremes among them.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_register(lbrh_pkg::REG_LOG_MIN, 32'h8000_0000);
                         write_register(lbrh_pkg::REG_LOG_MAX, 32'h7FFF_FFFF); end
                1: begin write_register(lbrh_pkg::REG_LOG_MIN, -32'sd2097152);
                         write_register(lbrh_pkg::REG_LOG_MAX, 32'sd1048576); end
                2: begin write_register(lbrh_pkg::REG_LOG_MIN, 32'sd100);
                         write_register(lbrh_pkg::REG_LOG_MAX, 32'sd100); end
                3: begin write_register(lbrh_pkg::REG_LOG_MIN, -32'sd20971520);
                         write_register(lbrh_pkg::REG_LOG_MAX, -32'sd20971519); end
                4: begin write_register(lbrh_pkg::REG_LOG_MIN, $urandom_range(0, 1) ?
                             -32'sd41943040 : -32'sd62914560);
                         write_register(lbrh_pkg::REG_LOG_MAX,
                                        32'($urandom_range(0, 2097152))); end
                default: begin write_register(lbrh_pkg::REG_LOG_MIN, -32'sd41943040);
                         write_register(lbrh_pkg::REG_LOG_MAX, 32'sd0); end
            endcase
            bursty = (ph == 1 || ph == 5);
            if (ph == 5) hold_long = 1'b1;
            for (int k = 0; k < 280; k++)
                send_item(random_item(1'b1),
                          (bursty && k % 40 < 20) ? 0 : $urandom_range(0, 14));
            drain_results();
        end

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Leftover expectations are caught by the drain, which would run into the cycle limit.
endmodule
